>>> rtl/gdec_pkg.sv
package gdec_pkg;

    localparam int TABLE_ENTRIES_DEF = 4096;
    localparam int MAX_CODE_BITS_DEF = 12;

    localparam int BUF_W = 20;
    localparam int BCNT_W = 5;
    localparam int CW_W = 4;
    localparam int CMP_W = 16;

    localparam logic [3:0] DEF_MIN_CODE_SIZE = 4'd8;
    localparam logic [3:0] MIN_SIZE = 4'd2;
    localparam logic [3:0] MAX_SIZE = 4'd8;

    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_PULL = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    localparam logic [2:0] ST_BYTE = 3'd0;
    localparam logic [2:0] ST_NEED = 3'd1;
    localparam logic [2:0] ST_REFUSED = 3'd2;
    localparam logic [2:0] ST_CLEAR = 3'd3;
    localparam logic [2:0] ST_END = 3'd4;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_byte;
    } item_t;

    function automatic logic [3:0] clamp_size(input logic [3:0] s);
        logic [3:0] r;
        r = s;
        if (s < MIN_SIZE) r = MIN_SIZE;
        if (s > MAX_SIZE) r = MAX_SIZE;
        return r;
    endfunction

endpackage

>>> rtl/gdec_front.sv
module gdec_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_cmd,
    input  logic [7:0]         s_data_byte,
    output logic               q_valid,
    input  logic               q_ready,
    output gdec_pkg::item_t    q_item
);

    gdec_pkg::item_t slot_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic            push, pop;

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item = slot_reg[rd_ptr_reg];
    assign push = s_valid && s_ready;
    assign pop = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next = cnt_reg;
        if (push && !pop) cnt_next = cnt_reg + 2'd1;
        if (pop && !push) cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg].cmd <= s_cmd;
            slot_reg[wr_ptr_reg].data_byte <= s_data_byte;
        end
    end

endmodule

>>> rtl/gdec_engine.sv
module gdec_engine #(
    parameter int TABLE_ENTRIES = gdec_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_CODE_BITS = gdec_pkg::MAX_CODE_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    input  logic [3:0]         cfg_data,
    input  logic               q_valid,
    output logic               q_ready,
    input  gdec_pkg::item_t    q_item,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_byte,
    output logic [2:0]         m_status,
    output logic               m_string_end
);

    localparam int ADDR_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = ADDR_W + 1;
    localparam int CODE_W = gdec_pkg::MAX_CODE_BITS_DEF;
    localparam int BUF_W = gdec_pkg::BUF_W;
    localparam int BCNT_W = gdec_pkg::BCNT_W;
    localparam int CW_W = gdec_pkg::CW_W;
    localparam int CMP_W = gdec_pkg::CMP_W;
    localparam logic [CMP_W-1:0] TE_C = CMP_W'(TABLE_ENTRIES);
    localparam logic [CW_W-1:0] MAXW = CW_W'(MAX_CODE_BITS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_FIN = 2'd2;
    localparam logic [1:0] S_POP = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [3:0]        msz_reg, msz_next;
    logic [3:0]        db_reg, db_next;
    logic [BUF_W-1:0]  bb_reg, bb_next;
    logic [BCNT_W-1:0] bc_reg, bc_next;
    logic [CW_W-1:0]   cw_reg, cw_next;
    logic [CNT_W-1:0]  nf_reg, nf_next;
    logic [ADDR_W-1:0] old_code_reg, old_code_next;
    logic              old_valid_reg, old_valid_next;
    logic [7:0]        old_first_reg, old_first_next;
    logic [CNT_W-1:0]  sc_reg, sc_next;
    logic              end_reg, end_next;
    logic [ADDR_W-1:0] code_reg, code_next;
    logic [7:0]        root_reg, root_next;

    logic              m_valid_reg;
    logic [7:0]        m_out_byte_reg;
    logic [2:0]        m_status_reg;
    logic              m_string_end_reg;

    logic              out_load;
    logic [7:0]        o_byte;
    logic [2:0]        o_status;
    logic              o_send;
    logic              out_free;

    logic [ADDR_W-1:0] prefix_mem [TABLE_ENTRIES];
    logic [7:0]        suffix_mem [TABLE_ENTRIES];
    logic [7:0]        stk_mem [TABLE_ENTRIES];
    logic [ADDR_W-1:0] prefix_q;
    logic [7:0]        suffix_q;
    logic [7:0]        stk_q;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              tbl_we;
    logic              stk_we;
    logic [ADDR_W-1:0] stk_waddr;
    logic [7:0]        stk_wdata;
    logic              stk_re;
    logic [ADDR_W-1:0] stk_raddr;

    logic [BUF_W-1:0]  mask;
    logic [CODE_W-1:0] code;
    logic [CMP_W-1:0]  code_c, nf_c, cc_c, old_c, pre_c, nf_inc;
    logic [3:0]        rs_size;

    assign out_free = !m_valid_reg || m_ready;
    assign mask = (BUF_W'(1) << cw_reg) - BUF_W'(1);
    assign code = CODE_W'(bb_reg & mask);
    assign code_c = CMP_W'(code);
    assign nf_c = CMP_W'(nf_reg);
    assign cc_c = CMP_W'(1) << db_reg;
    assign old_c = CMP_W'(old_code_reg);
    assign pre_c = CMP_W'(prefix_q);
    assign nf_inc = nf_c + CMP_W'(1);
    assign rs_size = gdec_pkg::clamp_size(msz_reg);

    always_comb begin
        state_next = state_reg;
        msz_next = cfg_valid ? cfg_data : msz_reg;
        db_next = db_reg;
        bb_next = bb_reg;
        bc_next = bc_reg;
        cw_next = cw_reg;
        nf_next = nf_reg;
        old_code_next = old_code_reg;
        old_valid_next = old_valid_reg;
        old_first_next = old_first_reg;
        sc_next = sc_reg;
        end_next = end_reg;
        code_next = code_reg;
        root_next = root_reg;
        q_ready = 1'b0;
        out_load = 1'b0;
        o_byte = 8'd0;
        o_status = gdec_pkg::ST_BYTE;
        o_send = 1'b0;
        rd_en = 1'b0;
        rd_addr = code[ADDR_W-1:0];
        tbl_we = 1'b0;
        stk_we = 1'b0;
        stk_waddr = sc_reg[ADDR_W-1:0];
        stk_wdata = suffix_q;
        stk_re = 1'b0;
        stk_raddr = ADDR_W'(sc_reg - CNT_W'(1));
        unique case (state_reg)
            S_IDLE: begin
                if (q_valid && out_free) begin
                    q_ready = 1'b1;
                    case (q_item.cmd)
                        gdec_pkg::CMD_PUSH: begin
                            if (bc_reg >= BCNT_W'(cw_reg)) begin
                                out_load = 1'b1;
                                o_status = gdec_pkg::ST_REFUSED;
                            end else begin
                                bb_next = bb_reg | (BUF_W'(q_item.data_byte) << bc_reg);
                                bc_next = bc_reg + BCNT_W'(8);
                            end
                        end
                        gdec_pkg::CMD_PULL: begin
                            if (sc_reg != '0) begin
                                stk_re = 1'b1;
                                sc_next = sc_reg - CNT_W'(1);
                                state_next = S_POP;
                            end else if (end_reg) begin
                                out_load = 1'b1;
                                o_status = gdec_pkg::ST_END;
                            end else if (bc_reg < BCNT_W'(cw_reg)) begin
                                out_load = 1'b1;
                                o_status = gdec_pkg::ST_NEED;
                            end else begin
                                bb_next = bb_reg >> cw_reg;
                                bc_next = bc_reg - BCNT_W'(cw_reg);
                                if (code_c == cc_c) begin
                                    nf_next = CNT_W'(cc_c + CMP_W'(2));
                                    cw_next = db_reg + 4'd1;
                                    old_valid_next = 1'b0;
                                    out_load = 1'b1;
                                    o_status = gdec_pkg::ST_CLEAR;
                                end else if (code_c == cc_c + CMP_W'(1)) begin
                                    end_next = 1'b1;
                                    out_load = 1'b1;
                                    o_status = gdec_pkg::ST_END;
                                end else if (code_c < cc_c) begin
                                    code_next = code[ADDR_W-1:0];
                                    root_next = code[7:0];
                                    state_next = S_FIN;
                                end else if (!old_valid_reg || code_c > nf_c
                                             || code_c >= TE_C
                                             || (code_c == nf_c && nf_c >= TE_C)) begin
                                    end_next = 1'b1;
                                    out_load = 1'b1;
                                    o_status = gdec_pkg::ST_END;
                                end else if (code_c == nf_c) begin
                                    stk_we = 1'b1;
                                    stk_waddr = '0;
                                    stk_wdata = old_first_reg;
                                    sc_next = CNT_W'(1);
                                    code_next = code[ADDR_W-1:0];
                                    if (old_c < cc_c) begin
                                        root_next = old_code_reg[7:0];
                                        state_next = S_FIN;
                                    end else begin
                                        rd_en = 1'b1;
                                        rd_addr = old_code_reg;
                                        state_next = S_WALK;
                                    end
                                end else begin
                                    code_next = code[ADDR_W-1:0];
                                    rd_en = 1'b1;
                                    state_next = S_WALK;
                                end
                            end
                        end
                        gdec_pkg::CMD_RESTART: begin
                            db_next = rs_size;
                            bb_next = '0;
                            bc_next = '0;
                            cw_next = rs_size + 4'd1;
                            nf_next = CNT_W'((CMP_W'(1) << rs_size) + CMP_W'(2));
                            old_code_next = '0;
                            old_valid_next = 1'b0;
                            sc_next = '0;
                            end_next = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WALK: begin
                stk_we = 1'b1;
                sc_next = sc_reg + CNT_W'(1);
                if (pre_c < cc_c) begin
                    root_next = prefix_q[7:0];
                    state_next = S_FIN;
                end else begin
                    rd_en = 1'b1;
                    rd_addr = prefix_q;
                end
            end
            S_FIN: begin
                out_load = 1'b1;
                o_byte = root_reg;
                o_send = (sc_reg == '0);
                if (old_valid_reg && nf_c < TE_C) begin
                    tbl_we = 1'b1;
                    nf_next = nf_reg + CNT_W'(1);
                    if (nf_inc == (CMP_W'(1) << cw_reg) && nf_inc < TE_C && cw_reg < MAXW)
                        cw_next = cw_reg + 4'd1;
                end
                old_code_next = code_reg;
                old_valid_next = 1'b1;
                old_first_next = root_reg;
                state_next = S_IDLE;
            end
            S_POP: begin
                out_load = 1'b1;
                o_byte = stk_q;
                o_send = (sc_reg == '0);
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            msz_reg <= gdec_pkg::DEF_MIN_CODE_SIZE;
            db_reg <= gdec_pkg::DEF_MIN_CODE_SIZE;
            bb_reg <= '0;
            bc_reg <= '0;
            cw_reg <= gdec_pkg::DEF_MIN_CODE_SIZE + 4'd1;
            nf_reg <= CNT_W'((CMP_W'(1) << gdec_pkg::DEF_MIN_CODE_SIZE) + CMP_W'(2));
            old_code_reg <= '0;
            old_valid_reg <= 1'b0;
            sc_reg <= '0;
            end_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            msz_reg <= msz_next;
            db_reg <= db_next;
            bb_reg <= bb_next;
            bc_reg <= bc_next;
            cw_reg <= cw_next;
            nf_reg <= nf_next;
            old_code_reg <= old_code_next;
            old_valid_reg <= old_valid_next;
            sc_reg <= sc_next;
            end_reg <= end_next;
            if (out_load) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        old_first_reg <= old_first_next;
        code_reg <= code_next;
        root_reg <= root_next;
        if (out_load) begin
            m_out_byte_reg <= o_byte;
            m_status_reg <= o_status;
            m_string_end_reg <= o_send;
        end
    end

    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            prefix_mem[nf_reg[ADDR_W-1:0]] <= old_code_reg;
            suffix_mem[nf_reg[ADDR_W-1:0]] <= root_reg;
        end
        if (rd_en) begin
            prefix_q <= prefix_mem[rd_addr];
            suffix_q <= suffix_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
        if (stk_re) stk_q <= stk_mem[stk_raddr];
    end

    assign m_valid = m_valid_reg;
    assign m_out_byte = m_out_byte_reg;
    assign m_status = m_status_reg;
    assign m_string_end = m_string_end_reg;

endmodule

>>> rtl/gif_lzw_decoder.sv
// GIF LZW decoder, 3 to 12 bit codes packed LSB first. Commands enter a two-item
// queue and run one at a time in the decode engine. A pull that decodes a code
// walks the code's prefix chain (one prefix/suffix memory read per cycle), pushing
// suffixes onto the string stack; a code equal to the next free entry has its own
// entry supplied from a register. The pull returns the string's first byte, and
// each later pull of that string pops one byte with a string-stack memory read. The
// result register holds one item, so a new command is taken while the previous
// result waits only when the result is taken in the same cycle. min_code_size is
// written through cfg_valid/cfg_data and takes effect at a restart command; reset
// restores the default of 8.
module gif_lzw_decoder #(
    parameter int TABLE_ENTRIES = gdec_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_CODE_BITS = gdec_pkg::MAX_CODE_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_cmd,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic [2:0] m_status,
    output logic       m_string_end
);

    logic            q_valid;
    logic            q_ready;
    gdec_pkg::item_t q_item;

    assign cfg_ready = 1'b1;

    gdec_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_data_byte (s_data_byte),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item)
    );

    gdec_engine #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_status     (m_status),
        .m_string_end (m_string_end)
    );

endmodule

>>> rtl/gdec_chk.sv
module gdec_chk (
    input logic       aclk,
    input logic       aresetn,
    input logic       cfg_valid,
    input logic       cfg_ready,
    input logic [3:0] cfg_data,
    input logic       s_valid,
    input logic       s_ready,
    input logic [1:0] s_cmd,
    input logic [7:0] s_data_byte,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic [2:0] m_status,
    input logic       m_string_end
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_out_byte))
        else $error("result changed while stalled");

    a_status_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != gdec_pkg::ST_BYTE |-> m_out_byte == 8'd0 && !m_string_end)
        else $error("status item carries byte data");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= gdec_pkg::ST_END)
        else $error("status code out of range");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind gif_lzw_decoder gdec_chk u_gdec_chk (.*);

>>> bench/gif_lzw_decoder_checker.sv
`timescale 1ns / 1ps

module gif_lzw_decoder_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [3:0] cfg_data,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [1:0] s_cmd,
    input  logic [7:0] s_data_byte,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_out_byte,
    input  logic [2:0] m_status,
    input  logic       m_string_end,
    output int         fails,
    output int         pending
);

    localparam int ENTRIES = 4096;
    localparam int WIDEST = 12;

    typedef struct {
        logic [7:0] out_byte;
        logic [2:0] status;
        logic       string_end;
    } decoded_t;

    decoded_t    decoded_q[$];

    logic [3:0]  size_reg;
    int unsigned root_bits;
    int unsigned bitbuf;
    int unsigned bitcnt;
    int unsigned width;
    int unsigned free_code;
    int unsigned prev_code;
    bit          prev_ok;
    int unsigned prefix_mem[ENTRIES];
    logic [7:0]  first_mem[ENTRIES];
    logic [7:0]  suffix_mem[ENTRIES];
    logic [7:0]  string_mem[ENTRIES];
    int unsigned depth;
    bit          ended;

    function automatic void expect_out(logic [7:0] b, logic [2:0] st, logic se);
        decoded_t d;
        d.out_byte = b;
        d.status = st;
        d.string_end = se;
        decoded_q.push_back(d);
    endfunction

    function automatic void restart_decoder();
        int unsigned s;
        s = size_reg;
        if (s < 2) s = 2;
        if (s > 8) s = 8;
        root_bits = s;
        bitbuf = 0;
        bitcnt = 0;
        width = s + 1;
        free_code = (1 << s) + 2;
        prev_code = 0;
        prev_ok = 0;
        depth = 0;
        ended = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            prefix_mem[i] = 0;
            first_mem[i] = (i < 256) ? i[7:0] : 8'd0;
            suffix_mem[i] = (i < 256) ? i[7:0] : 8'd0;
            string_mem[i] = 8'd0;
        end
    endfunction

    function automatic void grow_table(int unsigned prev, int unsigned src);
        if (free_code >= ENTRIES) return;
        prefix_mem[free_code] = prev;
        first_mem[free_code] = first_mem[prev];
        suffix_mem[free_code] = first_mem[src];
        free_code++;
        if (free_code == (1 << width) && free_code < ENTRIES && width < WIDEST)
            width++;
    endfunction

    function automatic void pop_string();
        depth--;
        expect_out(string_mem[depth % ENTRIES], gdec_pkg::ST_BYTE, depth == 0);
    endfunction

    function automatic void decode_pull();
        int unsigned code, cc, c, n;
        if (depth > 0) begin
            pop_string();
            return;
        end
        if (ended) begin
            expect_out(8'd0, gdec_pkg::ST_END, 1'b0);
            return;
        end
        if (bitcnt < width) begin
            expect_out(8'd0, gdec_pkg::ST_NEED, 1'b0);
            return;
        end
        code = bitbuf & ((1 << width) - 1);
        bitbuf = bitbuf >> width;
        bitcnt -= width;
        cc = 1 << root_bits;
        if (code == cc) begin
            free_code = cc + 2;
            width = root_bits + 1;
            prev_ok = 0;
            expect_out(8'd0, gdec_pkg::ST_CLEAR, 1'b0);
            return;
        end
        if (code == cc + 1) begin
            ended = 1;
            expect_out(8'd0, gdec_pkg::ST_END, 1'b0);
            return;
        end
        if (code < cc) begin
            if (prev_ok) grow_table(prev_code, code);
        end else begin
            if (!prev_ok || code > free_code || code >= ENTRIES) begin
                ended = 1;
                expect_out(8'd0, gdec_pkg::ST_END, 1'b0);
                return;
            end
            if (code == free_code) begin
                grow_table(prev_code, prev_code);
                if (code >= free_code) begin
                    ended = 1;
                    expect_out(8'd0, gdec_pkg::ST_END, 1'b0);
                    return;
                end
            end else begin
                grow_table(prev_code, code);
            end
        end
        prev_code = code;
        prev_ok = 1;
        c = code;
        n = 0;
        while (c >= cc && n < ENTRIES - 1) begin
            string_mem[n] = suffix_mem[c];
            n++;
            c = prefix_mem[c] % ENTRIES;
        end
        string_mem[n % ENTRIES] = suffix_mem[c % ENTRIES];
        depth = n + 1;
        pop_string();
    endfunction

    function automatic void apply_item(logic [1:0] cmd, logic [7:0] b);
        case (cmd)
            gdec_pkg::CMD_PUSH: begin
                if (bitcnt >= width) begin
                    expect_out(8'd0, gdec_pkg::ST_REFUSED, 1'b0);
                end else begin
                    bitbuf = (bitbuf | (int'(b) << bitcnt)) & 32'hfffff;
                    bitcnt += 8;
                end
            end
            gdec_pkg::CMD_PULL: decode_pull();
            gdec_pkg::CMD_RESTART: restart_decoder();
            default: ;
        endcase
    endfunction

    initial begin
        fails = 0;
        pending = 0;
    end

    always @(posedge aclk) begin
        decoded_t d;
        if (!aresetn) begin
            size_reg = gdec_pkg::DEF_MIN_CODE_SIZE;
            restart_decoder();
            decoded_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) size_reg = cfg_data;
            if (m_valid && m_ready) begin
                if (decoded_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected item: status %0d byte %0d end %0d",
                             $time, m_status, m_out_byte, m_string_end);
                end else begin
                    d = decoded_q.pop_front();
                    if (m_status !== d.status) begin
                        fails++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, d.status, m_status);
                    end
                    if (m_out_byte !== d.out_byte) begin
                        fails++;
                        $display("%0t: out_byte expected %0d actual %0d",
                                 $time, d.out_byte, m_out_byte);
                    end
                    if (m_string_end !== d.string_end) begin
                        fails++;
                        $display("%0t: string_end expected %0d actual %0d",
                                 $time, d.string_end, m_string_end);
                    end
                end
            end
            if (s_valid && s_ready) apply_item(s_cmd, s_data_byte);
        end
        pending <= decoded_q.size();
    end

endmodule

>>> bench/gif_lzw_decoder_test.sv
`timescale 1ns / 1ps

module gif_lzw_decoder_test;

    localparam logic [1:0] CMD_NOP = 2'd3;

    logic       aclk;
    logic       aresetn;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [3:0] cfg_data;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_cmd;
    logic [7:0] s_data_byte;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_byte;
    logic [2:0] m_status;
    logic       m_string_end;

    int         fails;
    int         pending;
    logic [2:0] last_status;
    bit         calm;

    logic [7:0]      packed_bytes[$];
    longint unsigned pack_acc;
    int              pack_bits;

    gif_lzw_decoder DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd), .s_data_byte(s_data_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_out_byte(m_out_byte),
        .m_status(m_status), .m_string_end(m_string_end)
    );

    gif_lzw_decoder_checker CHK (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd), .s_data_byte(s_data_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_out_byte(m_out_byte),
        .m_status(m_status), .m_string_end(m_string_end),
        .fails(fails), .pending(pending)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    initial begin
        #50_000_000;
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= 30);
        if (m_valid && m_ready) last_status <= m_status;
    end

    // send one item, then hold until every pending result is back
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] b);
        if (!calm && $urandom_range(0, 99) < 30)
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic write_size(input logic [3:0] v);
        repeat (40) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        send_item(gdec_pkg::CMD_RESTART, 8'($urandom_range(0, 255)));
    endtask

    function automatic void pack_code(int code, int w);
        pack_acc |= longint'(code) << pack_bits;
        pack_bits += w;
        while (pack_bits >= 8) begin
            packed_bytes.push_back(pack_acc[7:0]);
            pack_acc >>= 8;
            pack_bits -= 8;
        end
    endfunction

    // build a well-formed code stream; bad_at >= 0 ends it with an illegal code
    function automatic void make_stream(int size, int ncodes, bit roots_only, int bad_at);
        int cc, w, nf, code;
        bit ov, broken;
        cc = 1 << size;
        w = size + 1;
        nf = cc + 2;
        ov = 0;
        broken = 0;
        pack_acc = 0;
        pack_bits = 0;
        packed_bytes.delete();
        pack_code(cc, w);
        for (int k = 0; k < ncodes; k++) begin
            if (k == bad_at) begin
                if (!ov || nf + 1 >= (1 << w)) begin
                    if (ov) pack_code(cc, w);
                    w = size + 1;
                    pack_code(cc + 2, w);
                end else begin
                    pack_code(nf + 1, w);
                end
                broken = 1;
                break;
            end
            if (!roots_only && ov && $urandom_range(0, 39) == 0) begin
                pack_code(cc, w);
                w = size + 1;
                nf = cc + 2;
                ov = 0;
            end else begin
                if (!ov || roots_only) begin
                    code = $urandom_range(0, cc - 1);
                end else begin
                    code = $urandom_range(0, (nf < 4095) ? nf : 4095);
                    if (code == cc || code == cc + 1) code = (nf < 4095) ? nf : 0;
                end
                pack_code(code, w);
                if (ov && nf < 4096) begin
                    nf++;
                    if (nf == (1 << w) && nf < 4096 && w < 12) w++;
                end
                ov = 1;
            end
        end
        if (!broken) pack_code(cc + 1, w);
        if (pack_bits > 0) packed_bytes.push_back(pack_acc[7:0]);
    endfunction

    task automatic decode_stream();
        int idx;
        idx = 0;
        forever begin
            send_item(gdec_pkg::CMD_PULL, 8'($urandom_range(0, 255)));
            if (last_status == gdec_pkg::ST_NEED) begin
                if (idx >= packed_bytes.size()) break;
                send_item(gdec_pkg::CMD_PUSH, packed_bytes[idx]);
                idx++;
            end else if (last_status == gdec_pkg::ST_END) begin
                break;
            end
        end
    endtask

    task automatic noise(input int n);
        logic [1:0] c;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0: c = CMD_NOP;
                1: c = gdec_pkg::CMD_RESTART;
                2, 3, 4, 5: c = gdec_pkg::CMD_PUSH;
                default: c = gdec_pkg::CMD_PULL;
            endcase
            send_item(c, 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        logic [3:0] sizes [6];
        int sz;
        int nc;
        sizes = '{4'd2, 4'd15, 4'd1, 4'd3, 4'd9, 4'd6};
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 4'd0;
        s_valid = 1'b0;
        s_cmd = gdec_pkg::CMD_PUSH;
        s_data_byte = 8'd0;
        m_ready = 1'b0;
        last_status = gdec_pkg::ST_NEED;
        calm = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(gdec_pkg::CMD_PULL, 8'h00);
        send_item(gdec_pkg::CMD_PUSH, 8'hff);
        send_item(gdec_pkg::CMD_PUSH, 8'h00);
        send_item(gdec_pkg::CMD_PUSH, 8'h55);
        send_item(CMD_NOP, 8'haa);
        send_item(gdec_pkg::CMD_PULL, 8'hff);
        send_item(gdec_pkg::CMD_RESTART, 8'h00);
        send_item(gdec_pkg::CMD_PUSH, 8'h02);
        send_item(gdec_pkg::CMD_PUSH, 8'h00);
        send_item(gdec_pkg::CMD_PULL, 8'h00);
        send_item(gdec_pkg::CMD_PULL, 8'h00);
        send_item(gdec_pkg::CMD_RESTART, 8'h00);
        make_stream(8, 8, 0, -1);
        decode_stream();
        send_item(gdec_pkg::CMD_PULL, 8'h00);

        for (int p = 0; p < 6; p++) begin
            write_size(sizes[p]);
            sz = (sizes[p] < 2) ? 2 : (sizes[p] > 8) ? 8 : sizes[p];
            calm = (p == 3);
            for (int k = 0; k < 2; k++) begin
                nc = $urandom_range(3, 6);
                make_stream(sz, nc, 0, (k == 1) ? int'($urandom_range(0, nc - 1)) : -1);
                decode_stream();
                send_item(gdec_pkg::CMD_PULL, 8'($urandom_range(0, 255)));
                send_item(gdec_pkg::CMD_RESTART, 8'($urandom_range(0, 255)));
            end
            calm = 1'b0;
            noise(8);
        end

        write_size(4'd2);
        make_stream(2, 8, 1, -1);
        decode_stream();
        send_item(gdec_pkg::CMD_RESTART, 8'h00);

        do @(posedge aclk); while (pending != 0);
        repeat (50) @(posedge aclk);
        if (fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
